@@ rtl/sitda_pkg.sv @@
// Shared types and constants for the signed integer to decimal ASCII converter.
`default_nettype none

package sitda_pkg;

    localparam logic [6:0] ASCII_ZERO  = 7'd48;
    localparam logic [6:0] ASCII_MINUS = 7'd45;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CONV  = 5'b00010,
        S_SKIP  = 5'b00100,
        S_SIGN  = 5'b01000,
        S_DIGIT = 5'b10000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new request
        logic conv;      // one shift-and-add-3 step
        logic next_dig;  // drop the leading BCD digit
        logic sel_sign;  // present '-' instead of a digit
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic conv_done; // current conversion step is the last one
        logic top_zero;  // leading BCD digit is zero
        logic last_dig;  // leading BCD digit is the last one
        logic neg;       // request value was negative
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/sitda_ctrl.sv @@
// Controller FSM: sequences load, conversion, zero suppression and emission.
`default_nettype none

module sitda_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire sitda_pkg::t_dp_sts i_sts,
    output sitda_pkg::t_dp_cmd      o_cmd
);

    sitda_pkg::t_state r_state;
    sitda_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sitda_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        o_out_valid  = 1'b0;
        unique case (r_state)
            sitda_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = sitda_pkg::S_CONV;
                end
            end
            sitda_pkg::S_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_sts.conv_done) begin
                    n_state = sitda_pkg::S_SKIP;
                end
            end
            sitda_pkg::S_SKIP: begin
                // strip leading zeros, keeping at least one digit
                if (i_sts.top_zero && !i_sts.last_dig) begin
                    o_cmd.next_dig = 1'b1;
                end else if (i_sts.neg) begin
                    n_state = sitda_pkg::S_SIGN;
                end else begin
                    n_state = sitda_pkg::S_DIGIT;
                end
            end
            sitda_pkg::S_SIGN: begin
                o_out_valid    = 1'b1;
                o_cmd.sel_sign = 1'b1;
                if (i_out_ready) begin
                    n_state = sitda_pkg::S_DIGIT;
                end
            end
            sitda_pkg::S_DIGIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_sts.last_dig) begin
                        n_state = sitda_pkg::S_IDLE;
                    end else begin
                        o_cmd.next_dig = 1'b1;
                    end
                end
            end
            default: begin
                n_state = sitda_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/sitda_dp.sv @@
// Datapath: magnitude, double-dabble BCD register and character output.
`default_nettype none

module sitda_dp #(
    parameter int DATA_WIDTH = 32,
    parameter int NDIG       = 10
) (
    input  wire logic                   i_clk,
    input  wire logic signed [DATA_WIDTH-1:0] i_value,
    input  wire sitda_pkg::t_dp_cmd     i_cmd,
    output sitda_pkg::t_dp_sts          o_sts,
    output logic [6:0]                  o_character,
    output logic                        o_final_char
);

    localparam int BW   = $clog2(DATA_WIDTH);
    localparam int DCW  = $clog2(NDIG + 1);
    localparam int NBCD = NDIG * 4;

    logic [DATA_WIDTH-1:0] r_mag;
    logic [DATA_WIDTH-1:0] n_mag;
    logic [NBCD-1:0]       r_bcd;
    logic [NBCD-1:0]       n_bcd;
    logic [NBCD-1:0]       w_adj;
    logic [BW-1:0]         r_bit_cnt;
    logic [BW-1:0]         n_bit_cnt;
    logic [DCW-1:0]        r_dig_left;
    logic [DCW-1:0]        n_dig_left;
    logic                  r_neg;
    logic                  n_neg;
    logic [3:0]            w_top;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*4 +: 4] >= 4'd5) begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + 4'd3;
            end else begin
                w_adj[i*4 +: 4] = r_bcd[i*4 +: 4];
            end
        end
    end

    always_comb begin
        n_mag      = r_mag;
        n_bcd      = r_bcd;
        n_bit_cnt  = r_bit_cnt;
        n_dig_left = r_dig_left;
        n_neg      = r_neg;
        if (i_cmd.load) begin
            n_neg      = i_value[DATA_WIDTH-1];
            n_mag      = i_value[DATA_WIDTH-1] ? (~i_value + 1'b1) : i_value;
            n_bcd      = '0;
            n_bit_cnt  = BW'(DATA_WIDTH - 1);
            n_dig_left = DCW'(NDIG);
        end else if (i_cmd.conv) begin
            n_bcd     = {w_adj[NBCD-2:0], r_mag[DATA_WIDTH-1]};
            n_mag     = {r_mag[DATA_WIDTH-2:0], 1'b0};
            n_bit_cnt = r_bit_cnt - 1'b1;
        end else if (i_cmd.next_dig) begin
            n_bcd      = {r_bcd[NBCD-5:0], 4'd0};
            n_dig_left = r_dig_left - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_bcd      <= n_bcd;
        r_bit_cnt  <= n_bit_cnt;
        r_dig_left <= n_dig_left;
        r_neg      <= n_neg;
    end

    assign w_top = r_bcd[NBCD-1 -: 4];

    assign o_sts.conv_done = (r_bit_cnt == '0);
    assign o_sts.top_zero  = (w_top == 4'd0);
    assign o_sts.last_dig  = (r_dig_left == DCW'(1));
    assign o_sts.neg       = r_neg;

    assign o_character  = i_cmd.sel_sign ? sitda_pkg::ASCII_MINUS
                                         : (sitda_pkg::ASCII_ZERO + {3'd0, w_top});
    assign o_final_char = o_sts.last_dig && !i_cmd.sel_sign;

endmodule

`default_nettype wire

@@ rtl/signed_int_to_decimal_ascii.sv @@
// Top level: signed integer to decimal ASCII text converter.
//
// Converts one two's complement integer of DATA_WIDTH bits into its decimal
// text, one ASCII character per output request, most significant first: a
// '-' for negative values, leading zeros suppressed, "0" for zero, and
// o_final_char set on the last character. One request is handled at a time;
// o_in_ready is high only while the block is idle. Each request is loaded,
// then converted by DATA_WIDTH shift-and-add-3 steps in the
// double-dabble converter (one magnitude bit per cycle); each suppressed
// leading zero is then dropped in turn, a decision step picks sign or digit,
// and the characters are emitted, each held until the output takes it. At
// DATA_WIDTH 32 the BCD register holds 10 digits.
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed [DATA_WIDTH-1:0] i_value,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [6:0]                        o_character,
    output logic                              o_final_char
);

    // decimal digits needed for DATA_WIDTH bits (log10(2) ~ 1233/4096)
    localparam int NDIG = (DATA_WIDTH * 1233) / 4096 + 1;

    sitda_pkg::t_dp_cmd w_cmd;
    sitda_pkg::t_dp_sts w_sts;

    sitda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sitda_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .NDIG       (NDIG)
    ) u_dp (
        .i_clk        (i_clk),
        .i_value      (i_value),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_character  (o_character),
        .o_final_char (o_final_char)
    );

endmodule

`default_nettype wire

@@ rtl/sitda_chk.sv @@
// Port-level checker for the converter, bound to the top level.
`default_nettype none

module sitda_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [6:0] o_character,
    input wire logic       o_final_char
);

    // stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_character)
                                        && $stable(o_final_char))
        else $error("output changed while stalled");

    // never takes a new request while text is pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("ready while emitting");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accept");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_character == sitda_pkg::ASCII_MINUS)
                     || (o_character >= sitda_pkg::ASCII_ZERO
                         && o_character <= sitda_pkg::ASCII_ZERO + 7'd9))
        else $error("illegal character");

    // sign is never the last character, and a digit always follows it
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_character == sitda_pkg::ASCII_MINUS
        |-> !o_final_char ##1 (o_out_valid && o_character != sitda_pkg::ASCII_MINUS))
        else $error("sign misplaced");

endmodule

bind signed_int_to_decimal_ascii sitda_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_character  (o_character),
    .o_final_char (o_final_char)
);

`default_nettype wire
